FILE: hdl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define FISR_CHECK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Checked at every edge, reset included.
`define FISR_CHECK_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

FILE: hdl/fisr_pkg.sv
// Shared constants and helpers for the reciprocal square root pipeline.
`timescale 1ns / 1ps
package fisr_pkg;

  typedef logic [31:0] fp32_t;

  localparam fp32_t MAGIC_CLASSIC = 32'h5F3759DF;
  localparam fp32_t MAGIC_REFINED = 32'h5F375A86;
  localparam fp32_t MAGIC_OPT     = 32'h5F1FFFF9;
  localparam fp32_t FP_HALF       = 32'h3F000000;
  localparam fp32_t FP_ONE        = 32'h3F800000;
  localparam fp32_t FP_ONE_HALF   = 32'h3FC00000;
  localparam fp32_t FP_OPT_SCALE  = 32'h3F343637;  // 0.703952253
  localparam fp32_t FP_OPT_BIAS   = 32'h4018E962;  // 2.38924456
  localparam fp32_t FP_QNAN       = 32'h7FC00000;
  localparam fp32_t FP_INF        = 32'h7F800000;

  typedef enum logic [1:0] {
    VAR_CLASSIC = 2'd0,
    VAR_REFINED = 2'd1,
    VAR_OPT     = 2'd2,
    VAR_SPARE   = 2'd3
  } variant_t;

  localparam int PIPE_LAST = 16;

  // Leading zero count of a 48-bit word, 48 when zero.
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic       found;
    n     = 6'd48;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 6'(47 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

FILE: hdl/fisr_fmul.sv
// Three-stage single-precision multiplier, round to nearest even, subnormals kept.
`timescale 1ns / 1ps
module fisr_fmul (
  input  logic           clk,
  input  logic           en,
  input  fisr_pkg::fp32_t a,
  input  fisr_pkg::fp32_t b,
  output fisr_pkg::fp32_t r
);
  import fisr_pkg::*;

  logic               s1_sign_r, s1_nan_r, s1_inf_r;
  logic [47:0]        s1_prod_r;
  logic signed [10:0] s1_exp_r;

  logic               s2_sign_r, s2_nan_r, s2_inf_r, s2_zero_r;
  logic [47:0]        s2_norm_r;
  logic signed [10:0] s2_exp_r;

  fp32_t              r_r;

  logic [7:0]         a_e, b_e, a_ee, b_ee;
  logic [23:0]        a_m, b_m;
  logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic               nan_nxt, inf_nxt;
  logic [47:0]        prod_nxt;
  logic signed [10:0] exp_nxt;

  logic [5:0]         lz;
  logic [47:0]        norm_nxt;
  logic signed [10:0] e2_nxt;

  logic signed [10:0] diff;
  logic [7:0]         sh;
  logic [47:0]        shifted;
  logic               lost, ovf, inc;
  logic [7:0]         efld;
  logic [30:0]        packed_v, rounded;
  fp32_t              r_nxt;

  always_comb begin
    a_e    = a[30:23];
    b_e    = b[30:23];
    a_nan  = (a_e == 8'hFF) && (a[22:0] != 23'd0);
    b_nan  = (b_e == 8'hFF) && (b[22:0] != 23'd0);
    a_inf  = (a_e == 8'hFF) && (a[22:0] == 23'd0);
    b_inf  = (b_e == 8'hFF) && (b[22:0] == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    nan_nxt = a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
    inf_nxt = a_inf || b_inf;
    a_m  = {(a_e != 8'd0), a[22:0]};
    b_m  = {(b_e != 8'd0), b[22:0]};
    a_ee = (a_e == 8'd0) ? 8'd1 : a_e;
    b_ee = (b_e == 8'd0) ? 8'd1 : b_e;
    prod_nxt = 48'(a_m) * 48'(b_m);
    exp_nxt  = $signed({3'b000, a_ee}) + $signed({3'b000, b_ee}) - 11'sd127;
  end

  always_comb begin
    lz       = lzc48(s1_prod_r);
    norm_nxt = s1_prod_r << lz;
    e2_nxt   = s1_exp_r + 11'sd1 - $signed({5'b00000, lz});
  end

  always_comb begin
    diff    = 11'sd1 - s2_exp_r;
    sh      = (s2_exp_r > 11'sd0) ? 8'd0 : diff[7:0];
    shifted = s2_norm_r >> sh;
    lost    = |(s2_norm_r & ~({48{1'b1}} << sh));
    ovf     = (s2_exp_r >= 11'sd255);
    efld    = (s2_exp_r > 11'sd0) ? s2_exp_r[7:0] : 8'd0;
    inc     = shifted[23] && ((|shifted[22:0]) || lost || shifted[24]);
    packed_v = {efld, shifted[46:24]};
    rounded  = packed_v + 31'(inc);
    if (s2_nan_r) begin
      r_nxt = FP_QNAN;
    end else if (s2_inf_r || ovf) begin
      r_nxt = {s2_sign_r, FP_INF[30:0]};
    end else if (s2_zero_r) begin
      r_nxt = {s2_sign_r, 31'd0};
    end else begin
      r_nxt = {s2_sign_r, rounded};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sign_r <= a[31] ^ b[31];
      s1_nan_r  <= nan_nxt;
      s1_inf_r  <= inf_nxt;
      s1_prod_r <= prod_nxt;
      s1_exp_r  <= exp_nxt;
      s2_sign_r <= s1_sign_r;
      s2_nan_r  <= s1_nan_r;
      s2_inf_r  <= s1_inf_r;
      s2_zero_r <= (s1_prod_r == 48'd0);
      s2_norm_r <= norm_nxt;
      s2_exp_r  <= e2_nxt;
      r_r       <= r_nxt;
    end
  end

  assign r = r_r;

endmodule

FILE: hdl/fisr_fadd.sv
// Three-stage single-precision adder, round to nearest even, subnormals kept.
`timescale 1ns / 1ps
module fisr_fadd (
  input  logic           clk,
  input  logic           en,
  input  fisr_pkg::fp32_t a,
  input  fisr_pkg::fp32_t b,
  output fisr_pkg::fp32_t r
);
  import fisr_pkg::*;

  logic [26:0] s1_big_r, s1_sml_r;
  logic        s1_sub_r, s1_sign_r, s1_nan_r, s1_inf_r, s1_isign_r;
  logic [7:0]  s1_exp_r;

  logic [27:0] s2_sum_r;
  logic [5:0]  s2_lz_r;
  logic        s2_sub_r, s2_sign_r, s2_nan_r, s2_inf_r, s2_isign_r;
  logic [7:0]  s2_exp_r;

  fp32_t       r_r;

  fp32_t       big, sml;
  logic        a_ge, a_nan, b_nan, a_inf, b_inf;
  logic [7:0]  be, se, d;
  logic [26:0] bm, sm, sm_sh;
  logic        sm_lost;

  logic [27:0] sum_nxt;

  logic [26:0] s27;
  logic [8:0]  e9;
  logic [7:0]  l, lim, shv;
  logic        ovf, inc;
  logic [30:0] rounded;
  fp32_t       r_nxt;

  always_comb begin
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    a_ge  = (a[30:0] >= b[30:0]);
    big   = a_ge ? a : b;
    sml   = a_ge ? b : a;
    be    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    se    = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d     = be - se;
    bm    = {(big[30:23] != 8'd0), big[22:0], 3'b000};
    sm    = {(sml[30:23] != 8'd0), sml[22:0], 3'b000};
    sm_sh   = sm >> d;
    sm_lost = |(sm & ~({27{1'b1}} << d));
  end

  always_comb begin
    if (s1_sub_r) begin
      sum_nxt = {1'b0, s1_big_r} - {1'b0, s1_sml_r};
    end else begin
      sum_nxt = {1'b0, s1_big_r} + {1'b0, s1_sml_r};
    end
  end

  always_comb begin
    l   = {2'b00, s2_lz_r} - 8'd1;
    lim = s2_exp_r - 8'd1;
    shv = (l > lim) ? lim : l;
    if (s2_sum_r[27]) begin
      s27 = {s2_sum_r[27:2], s2_sum_r[1] | s2_sum_r[0]};
      e9  = {1'b0, s2_exp_r} + 9'd1;
    end else begin
      s27 = s2_sum_r[26:0] << shv;
      e9  = s27[26] ? ({1'b0, s2_exp_r} - {1'b0, shv}) : 9'd0;
    end
    ovf     = (e9 >= 9'd255);
    inc     = s27[2] && (s27[1] || s27[0] || s27[3]);
    rounded = {e9[7:0], s27[25:3]} + 31'(inc);
    if (s2_nan_r) begin
      r_nxt = FP_QNAN;
    end else if (s2_inf_r) begin
      r_nxt = {s2_isign_r, FP_INF[30:0]};
    end else if (s2_sum_r == 28'd0) begin
      r_nxt = {s2_sign_r && !s2_sub_r, 31'd0};
    end else if (ovf) begin
      r_nxt = {s2_sign_r, FP_INF[30:0]};
    end else begin
      r_nxt = {s2_sign_r, rounded};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_big_r   <= bm;
      s1_sml_r   <= sm_sh | {26'd0, sm_lost};
      s1_sub_r   <= a[31] ^ b[31];
      s1_sign_r  <= big[31];
      s1_exp_r   <= be;
      s1_nan_r   <= a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]));
      s1_inf_r   <= a_inf || b_inf;
      s1_isign_r <= a_inf ? a[31] : b[31];
      s2_sum_r   <= sum_nxt;
      s2_lz_r    <= lzc48({sum_nxt, 20'd0});
      s2_sub_r   <= s1_sub_r;
      s2_sign_r  <= s1_sign_r;
      s2_exp_r   <= s1_exp_r;
      s2_nan_r   <= s1_nan_r;
      s2_inf_r   <= s1_inf_r;
      s2_isign_r <= s1_isign_r;
      r_r        <= r_nxt;
    end
  end

  assign r = r_r;

endmodule

FILE: hdl/fast_inverse_sqrt_core.sv
// Pipelined fast reciprocal square root: magic-constant seed and one Newton step.
// Usage:
//   Input channel in_valid/in_ready/in_value_bits carries one float32 bit
//   pattern per item; output channel out_valid/out_ready/out_result_bits
//   returns one float32 approximation of 1/sqrt(x) per item, in order.
//   cfg_wr_en/cfg_wr_data write the variant select (0 classic, 1 refined
//   constant, 2 two-coefficient form, 3 as 0); write it only while idle.
// Timing:
//   One item per cycle while the output is not stalled: four 3-stage
//   multipliers and one 3-stage adder in a chain, plus an input and an
//   output register.
// Reset:
//   rst_n low clears all valid bits and sets the variant to 0.
// Stall:
//   When out_ready is low with a result waiting, the whole pipeline holds
//   and in_ready drops in the same cycle; nothing is lost or repeated.
//   NaN results come out as 0x7FC00000.
`timescale 1ns / 1ps
module fast_inverse_sqrt_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_value_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result_bits,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data
);
  import fisr_pkg::*;

  variant_t variant_r;
  logic     vld_r [0:PIPE_LAST];
  logic     en;

  fp32_t x0_r, y0_r;
  logic  v2_0_r;
  fp32_t y_pipe_r  [1:6];
  logic  v2_pipe_r [1:9];
  fp32_t mc_pipe_r [4:12];
  fp32_t out_r;

  fp32_t seed_sh, seed_magic, seed_y;
  logic  is_opt;
  fp32_t m0, mc, m1, m2, sv, rv, bias, neg_m2, out_nxt;

  assign en       = !vld_r[PIPE_LAST] || out_ready;
  assign in_ready = en;
  assign is_opt   = (variant_r == VAR_OPT);

  always_comb begin
    seed_sh = is_opt ? {1'b0, in_value_bits[31:1]}
                     : {in_value_bits[31], in_value_bits[31:1]};
    unique case (variant_r)
      VAR_REFINED: seed_magic = MAGIC_REFINED;
      VAR_OPT:     seed_magic = MAGIC_OPT;
      default:     seed_magic = MAGIC_CLASSIC;
    endcase
    seed_y = seed_magic - seed_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r <= VAR_CLASSIC;
    end else if (cfg_wr_en) begin
      variant_r <= variant_t'(cfg_wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= PIPE_LAST; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i <= PIPE_LAST; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r   <= in_value_bits;
      y0_r   <= seed_y;
      v2_0_r <= is_opt;
      y_pipe_r[1]  <= y0_r;
      for (int i = 2; i <= 6; i++) y_pipe_r[i] <= y_pipe_r[i-1];
      v2_pipe_r[1] <= v2_0_r;
      for (int i = 2; i <= 9; i++) v2_pipe_r[i] <= v2_pipe_r[i-1];
      mc_pipe_r[4] <= mc;
      for (int i = 5; i <= 12; i++) mc_pipe_r[i] <= mc_pipe_r[i-1];
      out_r <= out_nxt;
    end
  end

  // x scaled by 0.5 (or 1.0) and y scaled by 1.0 (or the optimized coefficient)
  fisr_fmul u_mul_x (.clk, .en, .a(x0_r), .b(v2_0_r ? FP_ONE : FP_HALF), .r(m0));
  fisr_fmul u_mul_c (.clk, .en, .a(y0_r), .b(v2_0_r ? FP_OPT_SCALE : FP_ONE), .r(mc));
  fisr_fmul u_mul_1 (.clk, .en, .a(m0), .b(y_pipe_r[3]), .r(m1));
  fisr_fmul u_mul_2 (.clk, .en, .a(m1), .b(y_pipe_r[6]), .r(m2));

  assign bias   = v2_pipe_r[9] ? FP_OPT_BIAS : FP_ONE_HALF;
  assign neg_m2 = {~m2[31], m2[30:0]};

  fisr_fadd u_sub   (.clk, .en, .a(bias), .b(neg_m2), .r(sv));
  fisr_fmul u_mul_r (.clk, .en, .a(mc_pipe_r[12]), .b(sv), .r(rv));

  assign out_nxt = ((rv[30:23] == 8'hFF) && (rv[22:0] != 23'd0)) ? FP_QNAN : rv;

  assign out_valid       = vld_r[PIPE_LAST];
  assign out_result_bits = out_r;

endmodule

FILE: hdl/fisr_checker.sv
// Port-level checks for the reciprocal square root core, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fisr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_result_bits
);

  `FISR_CHECK_ALWAYS(a_reset_clears, clk, !rst_n |=> !out_valid)
  `FISR_CHECK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_result_bits))
  `FISR_CHECK(a_ready_follows, clk, rst_n, in_ready == (!out_valid || out_ready))
  `FISR_CHECK(a_nan_canon, clk, rst_n, out_valid && (out_result_bits[30:23] == 8'hFF) && (out_result_bits[22:0] != 23'd0) |-> out_result_bits == 32'h7FC00000)

endmodule

bind fast_inverse_sqrt_core fisr_checker u_fisr_checker (.*);
